/* src/smau_pkg.sv */
// Package for the small matrix arithmetic unit: widths, codes, stage
// structs and the determinant step table. No dependencies.
package smau_pkg;

    localparam int MAX_DIM      = 3;
    localparam int ELEMENT_BITS = 32;
    localparam int DATA_W       = 32;
    localparam int STORE_DEPTH  = 2 * MAX_DIM * MAX_DIM;
    localparam int ADDR_W       = $clog2(STORE_DEPTH);
    localparam int LOAD_W       = 5;
    localparam int STEP_W       = 4;
    localparam int ELEM_KEEP    = (ELEMENT_BITS < DATA_W) ? ELEMENT_BITS : DATA_W;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DET = 2'd3
    } t_op;

    typedef enum logic {
        CFG_OPERATION = 1'b0,
        CFG_DIMENSION = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ALU_MUL   = 2'd0,   // p = a * b
        ALU_CHAIN = 2'd1,   // p = a * p (third factor of a triple)
        ALU_ADD   = 2'd2,
        ALU_SUB   = 2'd3
    } t_alu_op;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_WAIT,
        ST_ISSUE
    } t_seq_state;

    typedef struct packed {
        logic        valid;
        t_alu_op     alu_op;
        logic        acc_en;
        logic        neg;
        logic        first;
        logic        last;
        logic [1:0]  row;
        logic [1:0]  col;
        logic        last_run;
    } t_term;

    typedef struct packed {
        t_term              term;
        logic [ADDR_W-1:0]  addr_a;
        logic [ADDR_W-1:0]  addr_b;
    } t_issue;

    typedef struct packed {
        logic pipe_busy;
        logic out_full;
    } t_dp_status;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic [1:0]               row;
        logic [1:0]               col;
        logic                     last_run;
    } t_result;

    typedef struct packed {
        logic [ADDR_W-1:0] addr_a;
        logic [ADDR_W-1:0] addr_b;
        t_alu_op           alu_op;
        logic              acc_en;
        logic              neg;
    } t_det_step;

    localparam int DET3_STEPS = 12;
    localparam int DET2_STEPS = 2;

    function automatic logic active_dim3(input logic [1:0] dim);
        return (dim == 2'd3) && (MAX_DIM >= 3);
    endfunction

    function automatic logic [DATA_W-1:0] elem_in(input logic [DATA_W-1:0] v);
        return DATA_W'($signed(v[ELEM_KEEP-1:0]));
    endfunction

    // row-major store index of (r, c)
    function automatic logic [ADDR_W-1:0] elem_addr(input logic dim3,
                                                    input logic [1:0] r,
                                                    input logic [1:0] c);
        logic [ADDR_W-1:0] r2;
        r2 = ADDR_W'({r, 1'b0});
        return dim3 ? (r2 + ADDR_W'(r) + ADDR_W'(c)) : (r2 + ADDR_W'(c));
    endfunction

    // 3x3 determinant as six signed triple products; even steps form x*y,
    // odd steps multiply in z and accumulate.
    function automatic t_det_step det3_step(input logic [STEP_W-1:0] s);
        t_det_step d;
        d = '0;
        case (s)
            4'd0:  d = '{5'd0, 5'd4, ALU_MUL,   1'b0, 1'b0};
            4'd1:  d = '{5'd8, 5'd0, ALU_CHAIN, 1'b1, 1'b0};
            4'd2:  d = '{5'd0, 5'd5, ALU_MUL,   1'b0, 1'b0};
            4'd3:  d = '{5'd7, 5'd0, ALU_CHAIN, 1'b1, 1'b1};
            4'd4:  d = '{5'd1, 5'd3, ALU_MUL,   1'b0, 1'b0};
            4'd5:  d = '{5'd8, 5'd0, ALU_CHAIN, 1'b1, 1'b1};
            4'd6:  d = '{5'd1, 5'd5, ALU_MUL,   1'b0, 1'b0};
            4'd7:  d = '{5'd6, 5'd0, ALU_CHAIN, 1'b1, 1'b0};
            4'd8:  d = '{5'd2, 5'd3, ALU_MUL,   1'b0, 1'b0};
            4'd9:  d = '{5'd7, 5'd0, ALU_CHAIN, 1'b1, 1'b0};
            4'd10: d = '{5'd2, 5'd4, ALU_MUL,   1'b0, 1'b0};
            4'd11: d = '{5'd6, 5'd0, ALU_CHAIN, 1'b1, 1'b1};
            default: d = '0;
        endcase
        return d;
    endfunction

endpackage

/* src/smau_ifs.sv */
// Handshake channels of the small matrix arithmetic unit: element input,
// result output and configuration write. Depends on smau_pkg.
interface smau_elem_if import smau_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] element_value;

    modport source (output valid, output element_value, input ready);
    modport sink   (input valid, input element_value, output ready);
endinterface

interface smau_res_if import smau_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] result_value;
    logic [1:0]               result_row;
    logic [1:0]               result_col;
    logic                     last_of_run;

    modport source (output valid, output result_value, output result_row,
                    output result_col, output last_of_run, input ready);
    modport sink   (input valid, input result_value, input result_row,
                    input result_col, input last_of_run, output ready);
endinterface

interface smau_cfg_if import smau_pkg::*; ();
    logic       valid;
    logic       ready;
    logic       index;
    logic [1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* src/small_matrix_arith_unit_core.sv */
// Small matrix arithmetic unit: 2x2/3x3 add, subtract, multiply, determinant.
// Loading takes one beat per cycle. Each result is summed from terms issued to
// the single shared multiply/add unit: 1 for add/sub, dim for multiply, 2 or
// 12 for a 2x2/3x3 determinant. A result is not started until the pipeline is
// empty and the result before has been taken by the sink.
// Input is not ready while results are computed. Synchronous active-low
// reset clears config (add, 2x2), load count and all valid flags.
module small_matrix_arith_unit_core import smau_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    smau_elem_if.sink   i_elem,
    smau_cfg_if.sink    i_cfg,
    smau_res_if.source  o_res
);

    // configuration registers: to be written only while the block is idle; the block does not enforce it
    t_op        r_op;
    logic [1:0] r_dim;

    logic              elem_fire;
    logic              elem_ready;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    t_issue            issue;
    t_dp_status        status;
    logic              out_valid;
    t_result           result;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op  <= OP_ADD;
            r_dim <= 2'd2;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_OPERATION: r_op  <= t_op'(i_cfg.data);
                CFG_DIMENSION: r_dim <= i_cfg.data;
                default:       r_op  <= r_op;
            endcase
        end
    end

    // an element beat lands in the store at address load_count
    assign i_elem.ready = elem_ready;
    assign elem_fire    = i_elem.valid && elem_ready;

    smau_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_elem_fire  (elem_fire),
        .i_op         (r_op),
        .i_dim        (r_dim),
        .i_status     (status),
        .o_elem_ready (elem_ready),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_issue      (issue)
    );

    // store read -> shared unit -> accumulator -> result register
    smau_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (elem_in(i_elem.element_value)),
        .i_issue     (issue),
        .i_out_ready (o_res.ready),
        .o_status    (status),
        .o_out_valid (out_valid),
        .o_result    (result)
    );

    // result beat straight from the datapath output register
    assign o_res.valid        = out_valid;
    assign o_res.result_value = result.value;
    assign o_res.result_row   = result.row;
    assign o_res.result_col   = result.col;
    assign o_res.last_of_run  = result.last_run;

endmodule

/* src/smau_dpath.sv */
// Datapath: element store, shared multiply/add unit, accumulator and the
// result register. Depends on smau_pkg.
module smau_dpath import smau_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  t_issue            i_issue,
    input  logic              i_out_ready,
    output t_dp_status        o_status,
    output logic              o_out_valid,
    output t_result           o_result
);

    logic [DATA_W-1:0] mem [STORE_DEPTH];
    logic [DATA_W-1:0] r_rd_a;
    logic [DATA_W-1:0] r_rd_b;
    logic [DATA_W-1:0] r_p;
    logic [DATA_W-1:0] n_p;
    logic [DATA_W-1:0] r_acc;
    logic [DATA_W-1:0] n_acc;
    logic [DATA_W-1:0] term_val;
    t_term             r_s1;
    t_term             r_s2;
    logic              r_out_valid;
    t_result           r_out;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_a <= mem[i_issue.addr_a];
        r_rd_b <= mem[i_issue.addr_b];
    end

    // stage 1: the shared unit
    always_comb begin
        case (r_s1.alu_op)
            ALU_MUL:   n_p = r_rd_a * r_rd_b;
            ALU_CHAIN: n_p = r_rd_a * r_p;
            ALU_ADD:   n_p = r_rd_a + r_rd_b;
            ALU_SUB:   n_p = r_rd_a - r_rd_b;
            default:   n_p = r_rd_a;
        endcase
    end

    // stage 2: accumulate
    always_comb begin
        term_val = r_s2.neg ? (DATA_W'(0) - r_p) : r_p;
        n_acc    = (r_s2.first ? DATA_W'(0) : r_acc) + term_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1        <= '0;
            r_s2        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1 <= i_issue.term;
            r_s2 <= r_s1;
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_s2.valid && r_s2.acc_en && r_s2.last) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1.valid) begin
            r_p <= n_p;
        end
        if (r_s2.valid && r_s2.acc_en) begin
            r_acc <= n_acc;
            if (r_s2.last) begin
                r_out.value    <= n_acc;
                r_out.row      <= r_s2.row;
                r_out.col      <= r_s2.col;
                r_out.last_run <= r_s2.last_run;
            end
        end
    end

    assign o_status.pipe_busy = r_s1.valid | r_s2.valid;
    assign o_status.out_full  = r_out_valid;
    assign o_out_valid        = r_out_valid;
    assign o_result           = r_out;

endmodule

/* src/smau_seq.sv */
// Sequencer: load counting, job start, and per-result issue of operand
// addresses and unit commands. Depends on smau_pkg.
module smau_seq import smau_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_elem_fire,
    input  t_op               i_op,
    input  logic [1:0]        i_dim,
    input  t_dp_status        i_status,
    output logic              o_elem_ready,
    output logic              o_wr_en,
    output logic [ADDR_W-1:0] o_wr_addr,
    output t_issue            o_issue
);

    t_seq_state        r_state, n_state;
    logic [LOAD_W-1:0] r_load_cnt, n_load_cnt;
    t_op               r_op, n_op;
    logic              r_dim3, n_dim3;
    logic [1:0]        r_row, n_row;
    logic [1:0]        r_col, n_col;
    logic [STEP_W-1:0] r_step, n_step;

    logic              live_dim3;
    logic [LOAD_W-1:0] live_sq;
    logic [LOAD_W-1:0] need;
    logic [LOAD_W-1:0] cnt_inc;
    logic [1:0]        dim_last;
    logic [ADDR_W-1:0] base_b;
    logic [STEP_W-1:0] nsteps;
    logic [1:0]        k;
    logic              last_run;
    t_det_step         det3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_LOAD;
            r_load_cnt <= '0;
            r_op       <= OP_ADD;
            r_dim3     <= 1'b0;
            r_row      <= '0;
            r_col      <= '0;
            r_step     <= '0;
        end else begin
            r_state    <= n_state;
            r_load_cnt <= n_load_cnt;
            r_op       <= n_op;
            r_dim3     <= n_dim3;
            r_row      <= n_row;
            r_col      <= n_col;
            r_step     <= n_step;
        end
    end

    always_comb begin
        live_dim3 = active_dim3(i_dim);
        live_sq   = live_dim3 ? LOAD_W'(9) : LOAD_W'(4);
        need      = (i_op == OP_DET) ? live_sq : LOAD_W'({live_sq, 1'b0});
        cnt_inc   = r_load_cnt + LOAD_W'(1);

        o_elem_ready = (r_state == ST_LOAD);
        o_wr_en      = i_elem_fire && (r_load_cnt < LOAD_W'(STORE_DEPTH));
        o_wr_addr    = r_load_cnt[ADDR_W-1:0];

        dim_last = r_dim3 ? 2'd2 : 2'd1;
        base_b   = r_dim3 ? ADDR_W'(9) : ADDR_W'(4);
        k        = r_step[1:0];
        det3     = det3_step(r_step);
        last_run = (r_op == OP_DET) || ((r_row == dim_last) && (r_col == dim_last));

        o_issue                = '0;
        o_issue.term.row       = r_row;
        o_issue.term.col       = r_col;
        o_issue.term.last_run  = last_run;
        nsteps                 = STEP_W'(1);

        unique case (r_op) inside
            OP_ADD, OP_SUB: begin
                o_issue.addr_a      = elem_addr(r_dim3, r_row, r_col);
                o_issue.addr_b      = base_b + elem_addr(r_dim3, r_row, r_col);
                o_issue.term.alu_op = (r_op == OP_ADD) ? ALU_ADD : ALU_SUB;
                o_issue.term.acc_en = 1'b1;
                o_issue.term.first  = 1'b1;
                o_issue.term.last   = 1'b1;
                nsteps              = STEP_W'(1);
            end
            OP_MUL: begin
                o_issue.addr_a      = elem_addr(r_dim3, r_row, k);
                o_issue.addr_b      = base_b + elem_addr(r_dim3, k, r_col);
                o_issue.term.alu_op = ALU_MUL;
                o_issue.term.acc_en = 1'b1;
                o_issue.term.first  = (k == 2'd0);
                o_issue.term.last   = (k == dim_last);
                nsteps              = STEP_W'({1'b0, dim_last}) + STEP_W'(1);
            end
            OP_DET: begin
                if (r_dim3) begin
                    o_issue.addr_a      = det3.addr_a;
                    o_issue.addr_b      = det3.addr_b;
                    o_issue.term.alu_op = det3.alu_op;
                    o_issue.term.acc_en = det3.acc_en;
                    o_issue.term.neg    = det3.neg;
                    o_issue.term.first  = (r_step == STEP_W'(1));
                    o_issue.term.last   = (r_step == STEP_W'(DET3_STEPS - 1));
                    nsteps              = STEP_W'(DET3_STEPS);
                end else begin
                    // a00*a11 - a01*a10
                    o_issue.addr_a      = r_step[0] ? ADDR_W'(1) : ADDR_W'(0);
                    o_issue.addr_b      = r_step[0] ? ADDR_W'(2) : ADDR_W'(3);
                    o_issue.term.alu_op = ALU_MUL;
                    o_issue.term.acc_en = 1'b1;
                    o_issue.term.neg    = r_step[0];
                    o_issue.term.first  = !r_step[0];
                    o_issue.term.last   = r_step[0];
                    nsteps              = STEP_W'(DET2_STEPS);
                end
            end
            default: begin
                nsteps = STEP_W'(1);
            end
        endcase

        n_state    = r_state;
        n_load_cnt = r_load_cnt;
        n_op       = r_op;
        n_dim3     = r_dim3;
        n_row      = r_row;
        n_col      = r_col;
        n_step     = r_step;

        unique case (r_state)
            ST_LOAD: begin
                if (i_elem_fire) begin
                    if (cnt_inc >= need) begin
                        n_load_cnt = '0;
                        n_op       = i_op;
                        n_dim3     = live_dim3;
                        n_row      = '0;
                        n_col      = '0;
                        n_step     = '0;
                        n_state    = ST_WAIT;
                    end else begin
                        n_load_cnt = cnt_inc;
                    end
                end
            end
            ST_WAIT: begin
                if (!i_status.pipe_busy && !i_status.out_full) begin
                    n_state = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                o_issue.term.valid = 1'b1;
                if (r_step == nsteps - STEP_W'(1)) begin
                    n_step = '0;
                    if (last_run) begin
                        n_state = ST_LOAD;
                    end else begin
                        n_state = ST_WAIT;
                        if (r_col == dim_last) begin
                            n_col = '0;
                            n_row = r_row + 2'd1;
                        end else begin
                            n_col = r_col + 2'd1;
                        end
                    end
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

endmodule

/* sim/small_matrix_arith_unit_core_tb.sv */
// Self-checking testbench for small_matrix_arith_unit_core: streams matrix
// elements, predicts every result beat and compares them in order.
// Depends on smau_pkg, the smau_*_if channels and the core itself.
module small_matrix_arith_unit_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import smau_pkg::*;

    localparam logic [DATA_W-1:0] ELEM_MIN     = 32'h8000_0000;
    localparam logic [DATA_W-1:0] ELEM_MAX     = 32'h7fff_ffff;
    localparam logic [DATA_W-1:0] ELEM_NEG1    = 32'hffff_ffff;
    // worst job is a 3x3 product of 9 result beats; the settle time that
    // follows the last beat is ample before touching registers
    localparam int unsigned       SETTLE_CYCLES = 20;
    localparam int unsigned       DRAIN_CYCLES  = 60;
    localparam int unsigned       CYCLE_LIMIT   = 200_000;
    localparam int unsigned       PRINT_CAP     = 100;

    // traffic shaping per phase
    typedef enum int {
        FLOW_FREE,
        FLOW_SRC_IDLE,
        FLOW_SINK_STALL,
        FLOW_BOTH
    } t_flow;

    // Scoreboard: mirrors the matrix store, load count and config, and
    // queues the result beats each completed job should produce.
    class matrix_scoreboard;
        logic [DATA_W-1:0] elem_store [STORE_DEPTH];
        logic [LOAD_W-1:0] loaded;
        t_op               op_sel;
        logic [1:0]        dim_sel;
        t_result           expected_beats [$];
        int unsigned       mismatches;

        function new();
            foreach (elem_store[i]) elem_store[i] = '0;
            loaded     = '0;
            op_sel     = OP_ADD;
            dim_sel    = 2'd2;
            mismatches = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [1:0] val);
            case (idx)
                CFG_OPERATION: op_sel  = t_op'(val);
                CFG_DIMENSION: dim_sel = val;
                default: ;
            endcase
        endfunction

        function int unsigned pending();
            return expected_beats.size();
        endfunction

        function logic [DATA_W-1:0] entry(int unsigned base, int unsigned dim,
                                          int unsigned r, int unsigned c);
            int unsigned idx;
            idx = base + r * dim + c;
            return (idx < STORE_DEPTH) ? elem_store[idx] : '0;
        endfunction

        // cofactor expansion along row 0, wrapping at 32 bits
        function logic [DATA_W-1:0] det_value(int unsigned dim);
            if (dim == 2)
                return entry(0, 2, 0, 0) * entry(0, 2, 1, 1)
                     - entry(0, 2, 0, 1) * entry(0, 2, 1, 0);
            return entry(0, 3, 0, 0) * (entry(0, 3, 1, 1) * entry(0, 3, 2, 2)
                                       - entry(0, 3, 1, 2) * entry(0, 3, 2, 1))
                 - entry(0, 3, 0, 1) * (entry(0, 3, 1, 0) * entry(0, 3, 2, 2)
                                       - entry(0, 3, 1, 2) * entry(0, 3, 2, 0))
                 + entry(0, 3, 0, 2) * (entry(0, 3, 1, 0) * entry(0, 3, 2, 1)
                                       - entry(0, 3, 1, 1) * entry(0, 3, 2, 0));
        endfunction

        function void note_element(logic [DATA_W-1:0] v);
            int unsigned       dim, sq, need, r, c, k;
            logic [DATA_W-1:0] acc;
            logic signed [DATA_W-1:0] narrowed;
            t_result           beat;
            dim  = (dim_sel == 2'd3 && MAX_DIM >= 3) ? 3 : 2;
            sq   = dim * dim;
            need = (op_sel == OP_DET) ? sq : 2 * sq;
            // keep the low ELEM_KEEP bits, sign-extended
            narrowed = v << (DATA_W - ELEM_KEEP);
            if (loaded < STORE_DEPTH)
                elem_store[loaded] = narrowed >>> (DATA_W - ELEM_KEEP);
            loaded = loaded + 1'b1;
            if (loaded < need)
                return;
            loaded = '0;
            if (op_sel == OP_DET) begin
                beat.value    = det_value(dim);
                beat.row      = 2'd0;
                beat.col      = 2'd0;
                beat.last_run = 1'b1;
                expected_beats.push_back(beat);
                return;
            end
            for (r = 0; r < dim; r++) begin
                for (c = 0; c < dim; c++) begin
                    case (op_sel)
                        OP_ADD: acc = entry(0, dim, r, c) + entry(sq, dim, r, c);
                        OP_SUB: acc = entry(0, dim, r, c) - entry(sq, dim, r, c);
                        default: begin
                            acc = '0;
                            for (k = 0; k < dim; k++)
                                acc = acc + entry(0, dim, r, k) * entry(sq, dim, k, c);
                        end
                    endcase
                    beat.value    = acc;
                    beat.row      = 2'(r);
                    beat.col      = 2'(c);
                    beat.last_run = (r == dim - 1) && (c == dim - 1);
                    expected_beats.push_back(beat);
                end
            end
        endfunction

        task report_mismatch(string what);
            mismatches++;
            if (mismatches <= PRINT_CAP)
                $display("[%0t] result mismatch: %s", $realtime, what);
        endtask

        task check_result(t_result got);
            t_result want;
            if (expected_beats.size() == 0) begin
                report_mismatch($sformatf("unexpected beat value %0d row %0d col %0d",
                                          got.value, got.row, got.col));
                return;
            end
            want = expected_beats.pop_front();
            if (got.value !== want.value)
                report_mismatch($sformatf("value got %0d want %0d (row %0d col %0d)",
                                          got.value, want.value, want.row, want.col));
            if (got.row !== want.row)
                report_mismatch($sformatf("row got %0d want %0d", got.row, want.row));
            if (got.col !== want.col)
                report_mismatch($sformatf("col got %0d want %0d", got.col, want.col));
            if (got.last_run !== want.last_run)
                report_mismatch($sformatf("last_of_run got %0b want %0b (row %0d col %0d)",
                                          got.last_run, want.last_run, want.row, want.col));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    smau_elem_if elem_ch ();
    smau_cfg_if  cfg_ch ();
    smau_res_if  res_ch ();

    small_matrix_arith_unit_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_elem  (elem_ch),
        .i_cfg   (cfg_ch),
        .o_res   (res_ch)
    );

    matrix_scoreboard  sb;
    int unsigned       elem_idle_pct = 0;   // chance of a gap before each element
    int unsigned       res_stall_pct = 0;   // chance of ready low on a cycle
    int unsigned       cycle_count   = 0;
    t_result           res_beat;
    logic [DATA_W-1:0] directed_elems [25];

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Watchdog: a hung handshake or a lost result ends here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Result side: sample the beat seen at this edge, then pick the next
    // ready level. Values read here are the ones the core saw at the edge.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
            res_beat.value    = res_ch.result_value;
            res_beat.row      = res_ch.result_row;
            res_beat.col      = res_ch.result_col;
            res_beat.last_run = res_ch.last_of_run;
            sb.check_result(res_beat);
        end
        res_ch.ready <= ($urandom_range(0, 99) >= res_stall_pct);
    end

    // Mostly random 32-bit values, with the extremes and small numbers
    // mixed in so wraparound and sign handling get hit often.
    function automatic logic [DATA_W-1:0] pick_element();
        case ($urandom_range(0, 7))
            0: return ELEM_MIN;
            1: return ELEM_MAX;
            2: return DATA_W'($urandom_range(0, 8)) - DATA_W'(4);
            default: return DATA_W'($urandom);
        endcase
    endfunction

    // One element beat. Valid is only lowered on idle cycles, so a
    // back-to-back stream keeps valid high with a single NBA per edge.
    task automatic drive_element(logic [DATA_W-1:0] v);
        while ($urandom_range(0, 99) < elem_idle_pct) begin
            elem_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        elem_ch.valid         <= 1'b1;
        elem_ch.element_value <= v;
        do @(posedge i_clk); while (elem_ch.ready !== 1'b1);
        sb.note_element(v);
    endtask

    // Both registers in two consecutive beats; only called with the core idle.
    task automatic configure(t_op op, logic [1:0] dim);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= CFG_OPERATION;
        cfg_ch.data  <= op;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        sb.write_reg(CFG_OPERATION, op);
        cfg_ch.index <= CFG_DIMENSION;
        cfg_ch.data  <= dim;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        sb.write_reg(CFG_DIMENSION, dim);
        cfg_ch.valid <= 1'b0;
    endtask

    // Close a burst: drop valid, wait for every queued beat, then let the
    // core drain its pipeline before anyone touches the registers.
    task automatic finish_burst();
        elem_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        t_op         op;
        logic [1:0]  dim;
        t_flow       flow;
        int unsigned job_len, jobs, p, i;

        i_rst_n               <= 1'b0;
        elem_ch.valid         <= 1'b0;
        elem_ch.element_value <= '0;
        cfg_ch.valid          <= 1'b0;
        cfg_ch.index          <= CFG_OPERATION;
        cfg_ch.data           <= '0;
        sb = new();

        // Directed jobs:
        //  add 2x2 under reset config, overflow both ways
        //  subtract with dimension 1 (falls back to 2x2), extremes
        //  3x3 determinant with extremes
        directed_elems = '{
            ELEM_MAX, ELEM_MIN, ELEM_NEG1, 32'd0,
            32'd1, ELEM_NEG1, ELEM_NEG1, ELEM_MAX,
            ELEM_MIN, ELEM_MAX, 32'd0, 32'd1,
            32'd1, ELEM_NEG1, ELEM_MIN, ELEM_MAX,
            ELEM_MAX, ELEM_MIN, ELEM_NEG1,
            32'd2, 32'd3, ELEM_MIN,
            ELEM_NEG1, 32'd1, ELEM_MAX
        };

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (i = 0; i < 8; i++) drive_element(directed_elems[i]);
        finish_burst();
        configure(OP_SUB, 2'd1);
        for (i = 8; i < 16; i++) drive_element(directed_elems[i]);
        finish_burst();
        configure(OP_DET, 2'd3);
        for (i = 16; i < 25; i++) drive_element(directed_elems[i]);
        finish_burst();

        // Random phases: every operation against every dimension code,
        // traffic mode rotated so it does not track the dimension.
        for (p = 0; p < 16; p++) begin
            op   = t_op'(p / 4);
            dim  = 2'(p % 4);
            flow = t_flow'((p + p / 4) % 4);
            case (flow)
                FLOW_FREE:       begin elem_idle_pct = 0;  res_stall_pct = 0;  end
                FLOW_SRC_IDLE:   begin elem_idle_pct = 61; res_stall_pct = 0;  end
                FLOW_SINK_STALL: begin elem_idle_pct = 0;  res_stall_pct = 61; end
                default:         begin elem_idle_pct = 35; res_stall_pct = 35; end
            endcase
            configure(op, dim);
            job_len = ((dim == 2'd3) ? 9 : 4) * ((op == OP_DET) ? 1 : 2);
            jobs    = (14 + job_len - 1) / job_len;
            // whole jobs only, so the next config write lands on a boundary
            for (i = 0; i < jobs * job_len; i++) drive_element(pick_element());
            finish_burst();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* files.f */
src/smau_pkg.sv
src/smau_ifs.sv
src/smau_dpath.sv
src/smau_seq.sv
src/small_matrix_arith_unit_core.sv
sim/small_matrix_arith_unit_core_tb.sv
